@@ hdl/tmrq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the typed message ring queue.
package tmrq_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int CAP_W        = 13;
    localparam int CAP_MIN      = 16;
    localparam int LEN_W        = 12;

    typedef enum logic [1:0] {
        KIND_PUSH_HDR  = 2'd0,
        KIND_PUSH_BYTE = 2'd1,
        KIND_READ_MSG  = 2'd2,
        KIND_READ_BYTE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_MISUSE = 2'd3
    } status_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic over;
        logic neg;
        logic zero;
    } alu_flags_t;

    typedef struct packed {
        status_t          status;
        logic [LEN_W-1:0] found_length;
        logic [7:0]       byte_out;
        logic             last_byte;
    } result_t;

endpackage

@@ hdl/tmrq_alu.sv @@
`timescale 1ns / 1ps
// Shared modular add/subtract unit with compare flags.
module tmrq_alu
    import tmrq_pkg::*;
#(
    parameter int XW = 13
)
(
    input  alu_op_t       op,
    input  logic [XW-1:0] a,
    input  logic [XW-1:0] b,
    input  logic [XW-1:0] m,
    output logic [XW-1:0] res,
    output logic [XW-1:0] raw,
    output alu_flags_t    flags
);

    logic [XW:0] sum;
    logic [XW:0] dif;
    logic [XW:0] corr;

    always_comb
    begin
        sum   = {1'b0, a} + {1'b0, b};
        dif   = {1'b0, a} - {1'b0, b};
        corr  = '0;
        res   = '0;
        raw   = '0;
        flags = '0;
        case (op)
            ALU_ADD:
            begin
                // Wrap once by m; over flags a sum strictly above m
                corr       = sum - {1'b0, m};
                res        = (sum >= {1'b0, m}) ? corr[XW-1:0] : sum[XW-1:0];
                raw        = sum[XW-1:0];
                flags.over = (sum > {1'b0, m});
            end
            ALU_SUB:
            begin
                // Fold a borrow back into range by adding m
                corr      = dif + {1'b0, m};
                res       = dif[XW] ? corr[XW-1:0] : dif[XW-1:0];
                raw       = dif[XW-1:0];
                flags.neg = dif[XW];
            end
            default:
            begin
                res = '0;
            end
        endcase
        flags.zero = (res == '0);
    end

endmodule

@@ hdl/tmrq_ram.sv @@
`timescale 1ns / 1ps
// Single-port byte memory with registered read data.
module tmrq_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

@@ hdl/tmrq_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer and queue state for the typed message ring queue.
module tmrq_ctrl
    import tmrq_pkg::*;
#(
    parameter int AW = 12,
    parameter int XW = 13
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  kind_t            kind,
    input  logic [31:0]      msg_type,
    input  logic [LEN_W-1:0] msg_length,
    input  logic [7:0]       data_byte,
    input  logic [XW-1:0]    cap,
    input  logic             clear,
    output logic             idle,
    output logic             res_valid,
    input  logic             res_take,
    output result_t          res,
    output logic             mem_we,
    output logic             mem_re,
    output logic [AW-1:0]    mem_addr,
    output logic [7:0]       mem_wdata,
    input  logic [7:0]       mem_rdata,
    output alu_op_t          alu_op,
    output logic [XW-1:0]    alu_a,
    output logic [XW-1:0]    alu_b,
    output logic [XW-1:0]    alu_m,
    input  logic [XW-1:0]    alu_res,
    input  logic [XW-1:0]    alu_raw,
    input  alu_flags_t       alu_flags
);

    typedef enum logic [19:0] {
        S_IDLE     = 20'h00001,
        S_H_TOTAL  = 20'h00002,
        S_H_CHECK  = 20'h00004,
        S_H_WRITE  = 20'h00008,
        S_H_COMMIT = 20'h00010,
        S_P_WRITE  = 20'h00020,
        S_P_DEC    = 20'h00040,
        S_R_ADDR   = 20'h00080,
        S_R_DEC    = 20'h00100,
        S_R_SPAN   = 20'h00200,
        S_S_LOOP   = 20'h00400,
        S_S_FETCH  = 20'h00800,
        S_S_LAST   = 20'h01000,
        S_S_CLAMP  = 20'h02000,
        S_S_CUT    = 20'h04000,
        S_S_MATCH  = 20'h08000,
        S_S_SKIP   = 20'h10000,
        S_REL_SUB  = 20'h20000,
        S_REL_OFF  = 20'h40000,
        S_DONE     = 20'h80000
    } state_t;

    localparam logic [2:0]    HDR_LAST = 3'(HEADER_BYTES - 1);
    localparam logic [XW-1:0] HDR_X    = XW'(HEADER_BYTES);
    localparam logic [XW-1:0] ONE_X    = XW'(1);

    state_t           state_reg, state_next;
    logic [31:0]      type_reg, type_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       data_reg, data_next;
    logic [AW-1:0]    wr_off_reg, wr_off_next;
    logic [AW-1:0]    rd_off_reg, rd_off_next;
    logic [XW-1:0]    used_reg, used_next;
    logic [AW-1:0]    fill_off_reg, fill_off_next;
    logic [XW-1:0]    fill_rem_reg, fill_rem_next;
    logic [AW-1:0]    drain_off_reg, drain_off_next;
    logic [XW-1:0]    drain_rem_reg, drain_rem_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [XW-1:0]    total_reg, total_next;
    logic [XW-1:0]    tmp_reg, tmp_next;
    logic [XW-1:0]    n_reg, n_next;
    logic [XW-1:0]    hlen_reg, hlen_next;
    logic [63:0]      hdr_reg, hdr_next;
    logic             ret_reg, ret_next;
    result_t          res_reg, res_next;
    logic [63:0]      hdr_word;

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign hdr_word  = {32'(len_reg), type_reg};

    always_comb
    begin
        state_next     = state_reg;
        type_next      = type_reg;
        len_next       = len_reg;
        data_next      = data_reg;
        wr_off_next    = wr_off_reg;
        rd_off_next    = rd_off_reg;
        used_next      = used_reg;
        fill_off_next  = fill_off_reg;
        fill_rem_next  = fill_rem_reg;
        drain_off_next = drain_off_reg;
        drain_rem_next = drain_rem_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        tmp_next       = tmp_reg;
        n_next         = n_reg;
        hlen_next      = hlen_reg;
        hdr_next       = hdr_reg;
        ret_next       = ret_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = ptr_reg;
        mem_wdata      = '0;
        alu_op         = ALU_ADD;
        alu_a          = '0;
        alu_b          = '0;
        alu_m          = cap;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    type_next = msg_type;
                    len_next  = msg_length;
                    data_next = data_byte;
                    res_next  = '0;
                    unique case (kind)
                        KIND_PUSH_HDR:
                        begin
                            state_next = S_H_TOTAL;
                        end
                        KIND_PUSH_BYTE:
                        begin
                            if (fill_rem_reg == '0)
                            begin
                                res_next.status = STAT_MISUSE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_P_WRITE;
                            end
                        end
                        KIND_READ_MSG:
                        begin
                            drain_rem_next  = '0;
                            res_next.status = STAT_EMPTY;
                            state_next      = S_S_LOOP;
                        end
                        KIND_READ_BYTE:
                        begin
                            if (drain_rem_reg == '0)
                            begin
                                res_next.status = STAT_MISUSE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_R_ADDR;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_H_TOTAL:
            begin
                alu_a      = XW'(len_reg);
                alu_b      = HDR_X;
                total_next = alu_raw;
                state_next = S_H_CHECK;
            end
            S_H_CHECK:
            begin
                alu_a = used_reg;
                alu_b = total_reg;
                if (alu_flags.over)
                begin
                    res_next.status = STAT_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    tmp_next   = alu_raw;
                    ptr_next   = wr_off_reg;
                    cnt_next   = '0;
                    state_next = S_H_WRITE;
                end
            end
            S_H_WRITE:
            begin
                mem_we    = 1'b1;
                mem_wdata = hdr_word[{cnt_reg, 3'b000} +: 8];
                alu_a     = XW'(ptr_reg);
                alu_b     = ONE_X;
                ptr_next  = alu_res[AW-1:0];
                cnt_next  = cnt_reg + 3'd1;
                if (cnt_reg == HDR_LAST)
                begin
                    state_next = S_H_COMMIT;
                end
            end
            S_H_COMMIT:
            begin
                alu_a           = XW'(wr_off_reg);
                alu_b           = total_reg;
                wr_off_next     = alu_res[AW-1:0];
                fill_off_next   = ptr_reg;
                fill_rem_next   = XW'(len_reg);
                used_next       = tmp_reg;
                res_next.status = STAT_OK;
                state_next      = S_DONE;
            end
            S_P_WRITE:
            begin
                mem_we        = 1'b1;
                mem_addr      = fill_off_reg;
                mem_wdata     = data_reg;
                alu_a         = XW'(fill_off_reg);
                alu_b         = ONE_X;
                fill_off_next = alu_res[AW-1:0];
                state_next    = S_P_DEC;
            end
            S_P_DEC:
            begin
                alu_op          = ALU_SUB;
                alu_a           = fill_rem_reg;
                alu_b           = ONE_X;
                fill_rem_next   = alu_raw;
                res_next.status = STAT_OK;
                state_next      = S_DONE;
            end
            S_R_ADDR:
            begin
                mem_re         = 1'b1;
                mem_addr       = drain_off_reg;
                alu_a          = XW'(drain_off_reg);
                alu_b          = ONE_X;
                drain_off_next = alu_res[AW-1:0];
                state_next     = S_R_DEC;
            end
            S_R_DEC:
            begin
                alu_op            = ALU_SUB;
                alu_a             = drain_rem_reg;
                alu_b             = ONE_X;
                drain_rem_next    = alu_raw;
                res_next.status   = STAT_OK;
                res_next.byte_out = mem_rdata;
                if (alu_flags.zero)
                begin
                    res_next.last_byte = 1'b1;
                    state_next         = S_R_SPAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_R_SPAN:
            begin
                // Span from the front to the end of the drained payload
                alu_op     = ALU_SUB;
                alu_a      = XW'(drain_off_reg);
                alu_b      = XW'(rd_off_reg);
                n_next     = alu_flags.zero ? cap : alu_res;
                ret_next   = 1'b0;
                state_next = S_REL_SUB;
            end
            S_S_LOOP:
            begin
                alu_op = ALU_SUB;
                alu_a  = used_reg;
                alu_b  = HDR_X;
                if (used_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (alu_flags.neg)
                begin
                    // Runt tail: drop everything
                    n_next     = used_reg;
                    ret_next   = 1'b0;
                    state_next = S_REL_SUB;
                end
                else
                begin
                    ptr_next   = rd_off_reg;
                    cnt_next   = '0;
                    state_next = S_S_FETCH;
                end
            end
            S_S_FETCH:
            begin
                mem_re   = 1'b1;
                alu_a    = XW'(ptr_reg);
                alu_b    = ONE_X;
                ptr_next = alu_res[AW-1:0];
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg != '0)
                begin
                    hdr_next = {mem_rdata, hdr_reg[63:8]};
                end
                if (cnt_reg == HDR_LAST)
                begin
                    state_next = S_S_LAST;
                end
            end
            S_S_LAST:
            begin
                hdr_next   = {mem_rdata, hdr_reg[63:8]};
                state_next = S_S_CLAMP;
            end
            S_S_CLAMP:
            begin
                alu_a     = hdr_reg[32 +: XW];
                alu_b     = HDR_X;
                alu_m     = used_reg;
                hlen_next = hdr_reg[32 +: XW];
                if (alu_flags.over || (hdr_reg[63:32+XW] != '0))
                begin
                    state_next = S_S_CUT;
                end
                else
                begin
                    state_next = S_S_MATCH;
                end
            end
            S_S_CUT:
            begin
                alu_op     = ALU_SUB;
                alu_a      = used_reg;
                alu_b      = HDR_X;
                hlen_next  = alu_raw;
                state_next = S_S_MATCH;
            end
            S_S_MATCH:
            begin
                if (hdr_reg[31:0] == type_reg)
                begin
                    res_next.status       = STAT_OK;
                    res_next.found_length = hlen_reg[LEN_W-1:0];
                    drain_off_next        = ptr_reg;
                    drain_rem_next        = hlen_reg;
                    if (hlen_reg == '0)
                    begin
                        n_next     = HDR_X;
                        ret_next   = 1'b0;
                        state_next = S_REL_SUB;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_S_SKIP;
                end
            end
            S_S_SKIP:
            begin
                alu_a      = hlen_reg;
                alu_b      = HDR_X;
                n_next     = alu_raw;
                ret_next   = 1'b1;
                state_next = S_REL_SUB;
            end
            S_REL_SUB:
            begin
                alu_op = ALU_SUB;
                alu_a  = used_reg;
                alu_b  = n_reg;
                if (alu_flags.neg)
                begin
                    n_next    = used_reg;
                    used_next = '0;
                end
                else
                begin
                    used_next = alu_raw;
                end
                state_next = S_REL_OFF;
            end
            S_REL_OFF:
            begin
                alu_a       = XW'(rd_off_reg);
                alu_b       = n_reg;
                rd_off_next = alu_res[AW-1:0];
                state_next  = ret_reg ? S_S_LOOP : S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (clear)
        begin
            wr_off_next    = '0;
            rd_off_next    = '0;
            used_next      = '0;
            fill_off_next  = '0;
            fill_rem_next  = '0;
            drain_off_next = '0;
            drain_rem_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wr_off_reg    <= '0;
            rd_off_reg    <= '0;
            used_reg      <= '0;
            fill_off_reg  <= '0;
            fill_rem_reg  <= '0;
            drain_off_reg <= '0;
            drain_rem_reg <= '0;
            ret_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_off_reg    <= wr_off_next;
            rd_off_reg    <= rd_off_next;
            used_reg      <= used_next;
            fill_off_reg  <= fill_off_next;
            fill_rem_reg  <= fill_rem_next;
            drain_off_reg <= drain_off_next;
            drain_rem_reg <= drain_rem_next;
            ret_reg       <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg  <= type_next;
        len_reg   <= len_next;
        data_reg  <= data_next;
        ptr_reg   <= ptr_next;
        cnt_reg   <= cnt_next;
        total_reg <= total_next;
        tmp_reg   <= tmp_next;
        n_reg     <= n_next;
        hlen_reg  <= hlen_next;
        hdr_reg   <= hdr_next;
        res_reg   <= res_next;
    end

    a_used_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= cap)
        else $error("stored byte count exceeds capacity");

    a_offsets_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (XW'(rd_off_reg) < cap) && (XW'(wr_off_reg) < cap) &&
        (XW'(fill_off_reg) < cap) && (XW'(drain_off_reg) < cap))
        else $error("ring offset outside capacity");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !idle)
        else $error("sequencer idle right after accepting an item");

    a_fill_decrement: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_P_DEC) && !clear |=> fill_rem_reg == $past(fill_rem_reg) - ONE_X)
        else $error("payload fill count did not step down by one");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (used_reg == '0) && (fill_rem_reg == '0) && (drain_rem_reg == '0))
        else $error("capacity write left the queue non-empty");

endmodule

@@ hdl/typed_message_ring_queue_top.sv @@
`timescale 1ns / 1ps
// Top level of the typed message ring queue: config register, stream ports, result register.
//
//  Channel   Handshake                Payload
//  -------   ----------------------   ------------------------------------------------
//  cfg       psel/penable/pready      paddr, pwdata, prdata (capacity at address 0)
//  s (in)    s_tvalid/s_tready        s_tuser = kind, s_tdata = type, length, byte
//  m (out)   m_tvalid/m_tready        m_tuser = status, m_tdata = length, byte, m_tlast
//
// One item is worked at a time by a sequencer around a single modular add/subtract
// unit and a single-port byte memory; s_tready is high only while it is idle.
// push_header ends early when the queue lacks room; read_byte on the last byte also releases
// the message; push_byte or read_byte with nothing open goes straight to a misuse result; a
// read examines headers in turn, skips messages of another type, releases a zero-length
// match, drops a tail shorter than a header and stops when the stored bytes run out. The
// memory port, one byte per cycle, sets the pace of the header writes and fetches.
// Reset (rst_n, asynchronous) empties the queue and sets capacity to its default; no
// clearing pass is run, since never-written bytes are never read.
// A finished result waits in the output register; a stalled m_tready holds only the
// sequencer's final step, not the item already taken.
module typed_message_ring_queue_top
    import tmrq_pkg::*;
#(
    parameter int MAX_CAPACITY = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [31:0] msg_type, [43:32] msg_length, [51:44] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [11:0] found_length, [19:12] byte_out
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // last_byte
);

    localparam int AW        = $clog2(MAX_CAPACITY);
    localparam int XW        = (AW + 1 > CAP_W) ? AW + 1 : CAP_W;
    localparam int CAP_LIMIT = (MAX_CAPACITY < 8191) ? MAX_CAPACITY : 8191;
    localparam int CAP_DEF   = (MAX_CAPACITY < 4096) ? MAX_CAPACITY : 4096;
    localparam logic REG_CAPACITY = 1'b0;

    logic [CAP_W-1:0] cap_reg, cap_next;
    logic             cfg_wr;
    logic [CAP_W-1:0] cfg_val;
    logic [XW-1:0]    cap_x;

    logic             start;
    logic             idle;
    logic             res_valid;
    logic             res_take;
    result_t          res;
    result_t          out_reg;
    logic             m_tvalid_reg;

    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    mem_addr;
    logic [7:0]       mem_wdata;
    logic [7:0]       mem_rdata;

    alu_op_t          alu_op;
    logic [XW-1:0]    alu_a;
    logic [XW-1:0]    alu_b;
    logic [XW-1:0]    alu_m;
    logic [XW-1:0]    alu_res;
    logic [XW-1:0]    alu_raw;
    alu_flags_t       alu_flags;

    // Configuration: saturate the written capacity into its legal range
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign cfg_val = pwdata[CAP_W-1:0];
    assign prdata  = (paddr[2] == REG_CAPACITY) ? 32'(cap_reg) : '0;
    assign cap_x   = XW'(cap_reg);

    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_wr)
        begin
            if (cfg_val < CAP_W'(CAP_MIN))
            begin
                cap_next = CAP_W'(CAP_MIN);
            end
            else if (cfg_val > CAP_W'(CAP_LIMIT))
            begin
                cap_next = CAP_W'(CAP_LIMIT);
            end
            else
            begin
                cap_next = cfg_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(CAP_DEF);
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    // Input side: take an item only while the sequencer is idle
    assign s_tready = idle;
    assign start    = s_tvalid && idle;

    // Output side: load the result register when it is empty or being drained
    assign res_take = res_valid && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {4'b0, out_reg.byte_out, out_reg.found_length};
    assign m_tlast  = out_reg.last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    tmrq_ctrl #(
        .AW (AW),
        .XW (XW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .kind       (kind_t'(s_tuser)),
        .msg_type   (s_tdata[31:0]),
        .msg_length (s_tdata[43:32]),
        .data_byte  (s_tdata[51:44]),
        .cap        (cap_x),
        .clear      (cfg_wr),
        .idle       (idle),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res),
        .mem_we     (mem_we),
        .mem_re     (mem_re),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .mem_rdata  (mem_rdata),
        .alu_op     (alu_op),
        .alu_a      (alu_a),
        .alu_b      (alu_b),
        .alu_m      (alu_m),
        .alu_res    (alu_res),
        .alu_raw    (alu_raw),
        .alu_flags  (alu_flags)
    );

    tmrq_alu #(
        .XW (XW)
    ) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .m     (alu_m),
        .res   (alu_res),
        .raw   (alu_raw),
        .flags (alu_flags)
    );

    tmrq_ram #(
        .DEPTH (MAX_CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule
